// ----- rtl/tkst_pkg.sv -----
// Shared types, status codes and datapath operation codes for the top-k score table.
`default_nettype none
package tkst_pkg;

   // Fixed field widths of the request and response words.
   localparam int ID_W        = 32;
   localparam int SCORE_W     = 32;
   localparam int RANK_W      = 6;
   localparam int STATUS_W    = 3;
   localparam int COUNT_OUT_W = 7;

   // Request command codes.
   localparam logic CMD_SUBMIT = 1'b0;
   localparam logic CMD_READ   = 1'b1;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_READ_OK  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_BEYOND   = 3'd5;

   // Datapath operations issued by the controller.
   localparam logic [3:0] OP_NOP    = 4'd0;
   localparam logic [3:0] OP_SCAN   = 4'd1;
   localparam logic [3:0] OP_PLAN   = 4'd2;
   localparam logic [3:0] OP_DPRIME = 4'd3;
   localparam logic [3:0] OP_DSTEP  = 4'd4;
   localparam logic [3:0] OP_UPRIME = 4'd5;
   localparam logic [3:0] OP_USTEP  = 4'd6;
   localparam logic [3:0] OP_READ   = 4'd7;
   localparam logic [3:0] OP_RSP    = 4'd8;

   // Kinds of reorder pass chosen after the scan.
   localparam logic [1:0] PASS_NONE = 2'd0;
   localparam logic [1:0] PASS_DOWN = 2'd1;
   localparam logic [1:0] PASS_UP   = 2'd2;

   typedef struct packed {
      logic                cmd;
      logic [ID_W-1:0]     player_id;
      logic [SCORE_W-1:0]  score;
      logic [RANK_W-1:0]   rank_index;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [ID_W-1:0]        entry_id;
      logic [SCORE_W-1:0]     entry_score;
      logic [COUNT_OUT_W-1:0] entry_count;
   } rsp_word_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [SCORE_W-1:0] score;
   } entry_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic       req_take;
      logic [3:0] op;
   } ctl_type;

   // Datapath to controller status.
   typedef struct packed {
      logic       scan_done;
      logic [1:0] pass_kind;
      logic       pass_last;
      logic       rsp_free;
   } stat_type;

endpackage
`default_nettype wire

// ----- rtl/tkst_stream_if.sv -----
// Valid/ready stream interface carrying one payload word per handshake.
`default_nettype none
interface tkst_stream_if #(parameter type PAYLOAD_TYPE = logic) ();
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/tkst_datapath.sv -----
// Datapath of the top-k score table: entry memory, scan counters, reorder pass, response register.
`default_nettype none
module tkst_datapath #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire tkst_pkg::req_word_type req_word,
   input  wire tkst_pkg::ctl_type      ctl,
   output tkst_pkg::stat_type          stat,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output tkst_pkg::rsp_word_type      rsp_word
);

   localparam int AW   = $clog2(TABLE_DEPTH);
   localparam int CW   = $clog2(TABLE_DEPTH + 1);
   localparam int CMPW = (CW > tkst_pkg::COUNT_OUT_W) ? CW : tkst_pkg::COUNT_OUT_W;

   // Entry memory, one write and one registered read per cycle.
   tkst_pkg::entry_type entry_mem [TABLE_DEPTH];
   tkst_pkg::entry_type rd_data_ff;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   tkst_pkg::entry_type wr_data;

   // Request and table state.
   logic                          cmd_ff, cmd_in;
   logic [tkst_pkg::ID_W-1:0]     pid_ff, pid_in;
   logic [tkst_pkg::SCORE_W-1:0]  sc_ff, sc_in;
   logic [tkst_pkg::RANK_W-1:0]   idx_ff, idx_in;
   logic [CW-1:0]                 count_ff, count_in;

   // Scan results.
   logic [CW-1:0]       k_ff, k_in;
   logic                found_ff, found_in;
   logic [AW-1:0]       f_ff, f_in;
   logic [CW-1:0]       gt_ff, gt_in;
   logic [CW-1:0]       eqa_ff, eqa_in;
   logic [CW-1:0]       eqb_ff, eqb_in;
   tkst_pkg::entry_type last_ff, last_in;

   // Reorder pass state.
   logic [AW-1:0]       a_ff, a_in;
   logic [AW-1:0]       end_ff, end_in;
   tkst_pkg::entry_type hold_ff, hold_in;

   // Result of the current item.
   logic [tkst_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   tkst_pkg::entry_type           res_entry_ff, res_entry_in;
   logic                          in_range_ff, in_range_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   tkst_pkg::rsp_word_type        rsp_word_ff, rsp_word_in;

   // Helper values.
   logic [CW-1:0]   t_sum;
   logic [CW-1:0]   pos_sum;
   logic [CW-1:0]   f_wide;
   logic [CW-1:0]   scan_j;
   logic            table_full;
   logic            scan_done;
   logic            pass_last;
   logic [CMPW-1:0] idx_wide;
   logic [CMPW-1:0] count_wide;
   logic            idx_in_range;
   logic            match;
   logic [1:0]      plan_kind;
   logic [AW-1:0]   plan_start;
   logic [AW-1:0]   plan_end;

   assign t_sum        = gt_ff + eqb_ff;
   assign pos_sum      = gt_ff + eqa_ff;
   assign f_wide       = CW'(f_ff);
   assign scan_j       = k_ff - CW'(1);
   assign table_full   = (count_ff == CW'(TABLE_DEPTH));
   assign scan_done    = (k_ff == count_ff);
   assign pass_last    = (a_ff == end_ff);
   assign idx_wide     = CMPW'(idx_ff);
   assign count_wide   = CMPW'(count_ff);
   assign idx_in_range = (idx_wide < count_wide);
   assign match        = !found_ff && (rd_data_ff.id == pid_ff);

   // Choose the reorder pass. An updated entry lands after every other entry with a
   // higher score and after equal-score entries that stood before it.
   always_comb begin
      plan_kind  = tkst_pkg::PASS_NONE;
      plan_start = '0;
      plan_end   = '0;
      if (found_ff) begin
         if (t_sum > f_wide) begin
            plan_kind  = tkst_pkg::PASS_UP;
            plan_start = f_ff;
            plan_end   = t_sum[AW-1:0];
         end else begin
            plan_kind  = tkst_pkg::PASS_DOWN;
            plan_start = t_sum[AW-1:0];
            plan_end   = f_ff;
         end
      end else if (!table_full) begin
         plan_kind  = tkst_pkg::PASS_DOWN;
         plan_start = pos_sum[AW-1:0];
         plan_end   = count_ff[AW-1:0];
      end else if (pos_sum < count_ff) begin
         plan_kind  = tkst_pkg::PASS_DOWN;
         plan_start = pos_sum[AW-1:0];
         plan_end   = AW'(TABLE_DEPTH - 1);
      end
   end

   // Memory port control per operation.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = a_ff;
      wr_data = hold_ff;
      case (ctl.op)
         tkst_pkg::OP_SCAN: begin
            rd_en   = !scan_done;
            rd_addr = k_ff[AW-1:0];
         end
         tkst_pkg::OP_DPRIME: begin
            rd_en   = 1'b1;
            rd_addr = a_ff;
         end
         tkst_pkg::OP_DSTEP: begin
            wr_en   = 1'b1;
            rd_en   = !pass_last;
            rd_addr = a_ff + AW'(1);
         end
         tkst_pkg::OP_UPRIME: begin
            rd_en   = 1'b1;
            rd_addr = a_ff + AW'(1);
         end
         tkst_pkg::OP_USTEP: begin
            wr_en   = 1'b1;
            wr_data = pass_last ? hold_ff : rd_data_ff;
            rd_en   = !pass_last && ((a_ff + AW'(1)) != end_ff);
            rd_addr = a_ff + AW'(2);
         end
         tkst_pkg::OP_READ: begin
            rd_en   = idx_in_range;
            rd_addr = idx_wide[AW-1:0];
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // Next-state logic of the datapath registers.
   always_comb begin
      cmd_in        = cmd_ff;
      pid_in        = pid_ff;
      sc_in         = sc_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      k_in          = k_ff;
      found_in      = found_ff;
      f_in          = f_ff;
      gt_in         = gt_ff;
      eqa_in        = eqa_ff;
      eqb_in        = eqb_ff;
      last_in       = last_ff;
      a_in          = a_ff;
      end_in        = end_ff;
      hold_in       = hold_ff;
      res_status_in = res_status_ff;
      res_entry_in  = res_entry_ff;
      in_range_in   = in_range_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      // Capture a new request word and clear the scan results.
      if (ctl.req_take) begin
         cmd_in   = req_word.cmd;
         pid_in   = req_word.player_id;
         sc_in    = req_word.score;
         idx_in   = req_word.rank_index;
         k_in     = '0;
         found_in = 1'b0;
         gt_in    = '0;
         eqa_in   = '0;
         eqb_in   = '0;
      end

      case (ctl.op)
         // One entry per cycle: look for the id and count scores around the new one.
         tkst_pkg::OP_SCAN: begin
            if (k_ff != '0) begin
               last_in = rd_data_ff;
               if (match) begin
                  found_in = 1'b1;
                  f_in     = scan_j[AW-1:0];
               end
               if ((rd_data_ff.score > sc_ff) && !match) begin
                  gt_in = gt_ff + CW'(1);
               end
               if (rd_data_ff.score == sc_ff) begin
                  eqa_in = eqa_ff + CW'(1);
                  if (!found_ff && !match) begin
                     eqb_in = eqb_ff + CW'(1);
                  end
               end
            end
            if (!scan_done) begin
               k_in = k_ff + CW'(1);
            end
         end
         // Set up the pass bounds and the outcome of a submit.
         tkst_pkg::OP_PLAN: begin
            a_in         = plan_start;
            end_in       = plan_end;
            hold_in.id   = pid_ff;
            hold_in.score = sc_ff;
            res_entry_in = '0;
            if (found_ff) begin
               res_status_in = tkst_pkg::ST_UPDATED;
            end else if (!table_full) begin
               res_status_in = tkst_pkg::ST_INSERTED;
               count_in      = count_ff + CW'(1);
            end else if (pos_sum < count_ff) begin
               res_status_in = tkst_pkg::ST_DROPPED;
               res_entry_in  = last_ff;
            end else begin
               res_status_in = tkst_pkg::ST_REJECTED;
            end
         end
         tkst_pkg::OP_DSTEP: begin
            hold_in = rd_data_ff;
            a_in    = a_ff + AW'(1);
         end
         tkst_pkg::OP_USTEP: begin
            a_in = a_ff + AW'(1);
         end
         tkst_pkg::OP_READ: begin
            in_range_in = idx_in_range;
         end
         // Load the response register.
         tkst_pkg::OP_RSP: begin
            rsp_valid_in            = 1'b1;
            rsp_word_in.entry_count = count_wide[tkst_pkg::COUNT_OUT_W-1:0];
            if (cmd_ff == tkst_pkg::CMD_READ) begin
               if (in_range_ff) begin
                  rsp_word_in.status      = tkst_pkg::ST_READ_OK;
                  rsp_word_in.entry_id    = rd_data_ff.id;
                  rsp_word_in.entry_score = rd_data_ff.score;
               end else begin
                  rsp_word_in.status      = tkst_pkg::ST_BEYOND;
                  rsp_word_in.entry_id    = '0;
                  rsp_word_in.entry_score = '0;
               end
            end else begin
               rsp_word_in.status      = res_status_ff;
               rsp_word_in.entry_id    = res_entry_ff.id;
               rsp_word_in.entry_score = res_entry_ff.score;
            end
         end
         default: begin
            a_in = a_ff;
         end
      endcase
   end

   // Entry memory write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   // Entry memory read port with registered data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      pid_ff        <= pid_in;
      sc_ff         <= sc_in;
      idx_ff        <= idx_in;
      k_ff          <= k_in;
      found_ff      <= found_in;
      f_ff          <= f_in;
      gt_ff         <= gt_in;
      eqa_ff        <= eqa_in;
      eqb_ff        <= eqb_in;
      last_ff       <= last_in;
      a_ff          <= a_in;
      end_ff        <= end_in;
      hold_ff       <= hold_in;
      res_status_ff <= res_status_in;
      res_entry_ff  <= res_entry_in;
      in_range_ff   <= in_range_in;
      rsp_word_ff   <= rsp_word_in;
   end

   // Status to the controller and response outputs.
   assign stat.scan_done = scan_done;
   assign stat.pass_kind = plan_kind;
   assign stat.pass_last = pass_last;
   assign stat.rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_word       = rsp_word_ff;

endmodule
`default_nettype wire

// ----- rtl/tkst_ctrl.sv -----
// Controller state machine of the top-k score table.
`default_nettype none
module tkst_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_cmd,
   output logic                   req_ready,
   input  wire tkst_pkg::stat_type stat,
   output tkst_pkg::ctl_type      ctl
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SCAN   = 4'd1;
   localparam logic [3:0] S_PLAN   = 4'd2;
   localparam logic [3:0] S_DPRIME = 4'd3;
   localparam logic [3:0] S_DSTEP  = 4'd4;
   localparam logic [3:0] S_UPRIME = 4'd5;
   localparam logic [3:0] S_USTEP  = 4'd6;
   localparam logic [3:0] S_READ   = 4'd7;
   localparam logic [3:0] S_RESULT = 4'd8;

   logic [3:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   // Next state, word capture and datapath operation.
   always_comb begin
      state_in     = state_ff;
      ctl.req_take = req_valid && req_ready;
      ctl.op       = tkst_pkg::OP_NOP;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = (req_cmd == tkst_pkg::CMD_READ) ? S_READ : S_SCAN;
            end
         end
         S_SCAN: begin
            ctl.op = tkst_pkg::OP_SCAN;
            if (stat.scan_done) begin
               state_in = S_PLAN;
            end
         end
         S_PLAN: begin
            ctl.op = tkst_pkg::OP_PLAN;
            case (stat.pass_kind)
               tkst_pkg::PASS_DOWN: state_in = S_DPRIME;
               tkst_pkg::PASS_UP:   state_in = S_UPRIME;
               default:             state_in = S_RESULT;
            endcase
         end
         S_DPRIME: begin
            ctl.op   = tkst_pkg::OP_DPRIME;
            state_in = S_DSTEP;
         end
         S_DSTEP: begin
            ctl.op = tkst_pkg::OP_DSTEP;
            if (stat.pass_last) begin
               state_in = S_RESULT;
            end
         end
         S_UPRIME: begin
            ctl.op   = tkst_pkg::OP_UPRIME;
            state_in = S_USTEP;
         end
         S_USTEP: begin
            ctl.op = tkst_pkg::OP_USTEP;
            if (stat.pass_last) begin
               state_in = S_RESULT;
            end
         end
         S_READ: begin
            ctl.op   = tkst_pkg::OP_READ;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (stat.rsp_free) begin
               ctl.op   = tkst_pkg::OP_RSP;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/top_k_score_table_unit.sv -----
// Top level of the top-k score table: controller and datapath joined by command and status.
//
//   Channel  Direction  Word                       Handshake
//   req_ch   in         cmd, player_id, score,     valid/ready
//                       rank_index
//   rsp_ch   out        status, entry_id,          valid/ready
//                       entry_score, entry_count
//
// One word at a time. A read reads its entry and then loads the response once the response
// register is free. A submit scans one entry a cycle, plans the pass, moves entries between
// the old and new rank (none on a reject) and then loads the response in the same way.
// The next word is accepted in the cycle after the load. Reset clears the entry count and
// the response valid; the entry memory needs no clearing. A waiting response stalls only
// the end of the next word, never its acceptance.
`default_nettype none
module top_k_score_table_unit #(
   parameter int TABLE_DEPTH = 64
) (
   input wire logic      clock,
   input wire logic      reset,
   tkst_stream_if.sink   req_ch,
   tkst_stream_if.source rsp_ch
);

   tkst_pkg::ctl_type      ctl;
   tkst_pkg::stat_type     stat;
   tkst_pkg::req_word_type req_word;
   tkst_pkg::rsp_word_type rsp_word;
   logic                   req_ready;
   logic                   rsp_valid;

   assign req_word       = req_ch.payload;
   assign req_ch.ready   = req_ready;
   assign rsp_ch.valid   = rsp_valid;
   assign rsp_ch.payload = rsp_word;

   // Sequencer.
   tkst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_word.cmd),
      .req_ready (req_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   // Table storage and arithmetic.
   tkst_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .ctl       (ctl),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_word  (rsp_word)
   );

endmodule
`default_nettype wire

// ----- bench/top_k_score_table_unit_test.sv -----
// Self-checking testbench for the top-k score table: random and directed words, scoreboarded.
`timescale 1ns / 100ps

module top_k_score_table_unit_test;

   localparam int TABLE_DEPTH    = 64;
   localparam int PHASE_ITEMS    = 440;
   localparam int HOLD_CYCLES    = 600;
   localparam int DRAIN_CYCLES   = 2 * TABLE_DEPTH + 16;
   localparam int ID_POOL        = 80;
   localparam int ID_W           = tkst_pkg::ID_W;
   localparam int SCORE_W        = tkst_pkg::SCORE_W;
   localparam int RANK_W         = tkst_pkg::RANK_W;

   // Scoreboard that keeps its own ranked table and the queue of responses still to come.
   class score_table_scoreboard;
      bit [ID_W-1:0]          ranked_ids[TABLE_DEPTH];
      bit [SCORE_W-1:0]       ranked_scores[TABLE_DEPTH];
      int                     entry_total;
      tkst_pkg::rsp_word_type awaited_rsps[$];
      int                     error_count;

      function new();
         entry_total = 0;
         error_count = 0;
      endfunction

      function int outstanding();
         return awaited_rsps.size();
      endfunction

      // Stable descending insertion sort over the occupied ranks.
      function void resort_ranks();
         bit [ID_W-1:0]    held_id;
         bit [SCORE_W-1:0] held_score;
         int               i;
         int               j;
         for (i = 1; i < entry_total; i++) begin
            held_id    = ranked_ids[i];
            held_score = ranked_scores[i];
            j = i;
            while (j > 0 && ranked_scores[j-1] < held_score) begin
               ranked_ids[j]    = ranked_ids[j-1];
               ranked_scores[j] = ranked_scores[j-1];
               j--;
            end
            ranked_ids[j]    = held_id;
            ranked_scores[j] = held_score;
         end
      endfunction

      // Open a hole at the given rank by shifting lower entries down one place, and place the entry there.
      function void place_entry(int pos, bit [ID_W-1:0] id, bit [SCORE_W-1:0] score);
         int k;
         for (k = entry_total; k > pos; k--) begin
            ranked_ids[k]    = ranked_ids[k-1];
            ranked_scores[k] = ranked_scores[k-1];
         end
         ranked_ids[pos]    = id;
         ranked_scores[pos] = score;
         entry_total++;
      endfunction

      // Apply one accepted request word to the table and queue the response it causes.
      function void note_request(tkst_pkg::req_word_type word);
         tkst_pkg::rsp_word_type rsp;
         int                     slot;
         int                     pos;
         int                     i;
         rsp  = '0;
         slot = -1;
         if (word.cmd == tkst_pkg::CMD_READ) begin
            if (int'(word.rank_index) < entry_total) begin
               rsp.status      = tkst_pkg::ST_READ_OK;
               rsp.entry_id    = ranked_ids[word.rank_index];
               rsp.entry_score = ranked_scores[word.rank_index];
            end else begin
               rsp.status = tkst_pkg::ST_BEYOND;
            end
         end else begin
            for (i = 0; i < entry_total; i++) begin
               if (slot < 0 && ranked_ids[i] == word.player_id) slot = i;
            end
            if (slot >= 0) begin
               ranked_scores[slot] = word.score;
               resort_ranks();
               rsp.status = tkst_pkg::ST_UPDATED;
            end else begin
               pos = 0;
               while (pos < entry_total && ranked_scores[pos] >= word.score) pos++;
               if (entry_total < TABLE_DEPTH) begin
                  place_entry(pos, word.player_id, word.score);
                  rsp.status = tkst_pkg::ST_INSERTED;
               end else if (pos < entry_total) begin
                  rsp.entry_id    = ranked_ids[entry_total-1];
                  rsp.entry_score = ranked_scores[entry_total-1];
                  entry_total--;
                  place_entry(pos, word.player_id, word.score);
                  rsp.status = tkst_pkg::ST_DROPPED;
               end else begin
                  rsp.status = tkst_pkg::ST_REJECTED;
               end
            end
         end
         rsp.entry_count = entry_total[tkst_pkg::COUNT_OUT_W-1:0];
         awaited_rsps    = {awaited_rsps, rsp};
      endfunction

      // Print one line per mismatch and count every one.
      task report_mismatch(string msg);
         $display("MISMATCH at %0t: %s", $time, msg);
         error_count++;
      endtask

      // Compare a delivered response word with the oldest one still awaited; flag one when none is awaited.
      task check_result(tkst_pkg::rsp_word_type got);
         tkst_pkg::rsp_word_type want;
         if (awaited_rsps.size() == 0) begin
            report_mismatch($sformatf("response with none awaited: st=%0d id=%h sc=%h n=%0d",
                                      got.status, got.entry_id, got.entry_score,
                                      got.entry_count));
         end else begin
            want = awaited_rsps.pop_front();
            if (got.status !== want.status || got.entry_id !== want.entry_id ||
                got.entry_score !== want.entry_score || got.entry_count !== want.entry_count)
               report_mismatch($sformatf(
                  "got st=%0d id=%h sc=%h n=%0d, want st=%0d id=%h sc=%h n=%0d",
                  got.status, got.entry_id, got.entry_score, got.entry_count,
                  want.status, want.entry_id, want.entry_score, want.entry_count));
         end
      endtask
   endclass

   logic clock;
   logic reset;

   tkst_stream_if #(.PAYLOAD_TYPE(tkst_pkg::req_word_type)) req_if ();
   tkst_stream_if #(.PAYLOAD_TYPE(tkst_pkg::rsp_word_type)) rsp_if ();

   top_k_score_table_unit #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if.sink),
      .rsp_ch (rsp_if.source)
   );

   score_table_scoreboard board = new();

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   bit hold_request       = 1'b0;
   int hold_left          = 0;

   // Clock with a 10 ns period.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Watch both channels at the rising edge and feed the scoreboard.
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) board.note_request(req_if.payload);
      if (!reset && rsp_if.valid && rsp_if.ready) board.check_result(rsp_if.payload);
   end

   // Response ready: random stalls, or a long hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   function automatic tkst_pkg::req_word_type make_req(logic cmd, logic [ID_W-1:0] id,
                                                       logic [SCORE_W-1:0] score,
                                                       logic [RANK_W-1:0] rank);
      tkst_pkg::req_word_type word;
      word.cmd        = cmd;
      word.player_id  = id;
      word.score      = score;
      word.rank_index = rank;
      return word;
   endfunction

   // Random word: mostly submits from a small id pool so the table fills, updates and drops.
   function automatic tkst_pkg::req_word_type random_req();
      tkst_pkg::req_word_type word;
      word.cmd        = ($urandom_range(99) < 25) ? tkst_pkg::CMD_READ : tkst_pkg::CMD_SUBMIT;
      word.rank_index = RANK_W'($urandom_range(63));
      if ($urandom_range(9) == 0) word.player_id = $urandom;
      else word.player_id = ID_W'($urandom_range(ID_POOL - 1));
      case ($urandom_range(9))
         0, 1, 2, 3: word.score = SCORE_W'($urandom_range(15));
         4:          word.score = '0;
         5:          word.score = '1;
         default:    word.score = $urandom;
      endcase
      return word;
   endfunction

   // Offer one word, idling at random first, and return once it is accepted.
   task automatic drive_request(input tkst_pkg::req_word_type word);
      bit taken;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         if ($urandom_range(99) < sender_idle_pct) begin
            req_if.valid <= 1'b0;
         end else begin
            req_if.valid   <= 1'b1;
            req_if.payload <= word;
            do @(posedge clock); while (!req_if.ready);
            taken = 1'b1;
         end
      end
   endtask

   // Stimulus: reset, directed words, then four phases of random words with varying idling and stalls.
   initial begin
      tkst_pkg::req_word_type directed[$];
      int                     phase;
      int                     n;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty table reads, extreme ids and scores, ties, updates up and down.
      directed = {directed, make_req(tkst_pkg::CMD_READ, '0, '0, 6'd0)};
      directed = {directed, make_req(tkst_pkg::CMD_READ, '1, '1, 6'd63)};
      directed = {directed, make_req(tkst_pkg::CMD_SUBMIT, '0, '0, 6'd0)};
      directed = {directed, make_req(tkst_pkg::CMD_SUBMIT, '1, '1, 6'd63)};
      directed = {directed, make_req(tkst_pkg::CMD_SUBMIT, 32'd5, '0, 6'd0)};
      directed = {directed, make_req(tkst_pkg::CMD_SUBMIT, 32'd7, 32'd100, 6'd0)};
      directed = {directed, make_req(tkst_pkg::CMD_SUBMIT, '0, 32'd100, 6'd0)};
      directed = {directed, make_req(tkst_pkg::CMD_SUBMIT, 32'd7, '0, 6'd0)};
      directed = {directed, make_req(tkst_pkg::CMD_SUBMIT, 32'd5, '1, 6'd0)};
      directed = {directed, make_req(tkst_pkg::CMD_SUBMIT, 32'd5, '1, 6'd0)};
      for (n = 0; n < 6; n++)
         directed = {directed, make_req(tkst_pkg::CMD_READ, '0, '0, RANK_W'(n))};
      directed = {directed, make_req(tkst_pkg::CMD_READ, '0, '0, 6'd63)};
      directed = {directed, make_req(tkst_pkg::CMD_SUBMIT, '0, '1, 6'd0)};
      directed = {directed, make_req(tkst_pkg::CMD_SUBMIT, 32'h8000_0001, 32'h7FFF_FFFF,
                                     6'd0)};
      directed = {directed, make_req(tkst_pkg::CMD_READ, '0, '0, 6'd0)};
      directed = {directed, make_req(tkst_pkg::CMD_READ, '0, '0, 6'd3)};
      foreach (directed[i]) drive_request(directed[i]);

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 79; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 79; end
            default: begin sender_idle_pct = 33; receiver_stall_pct = 33; end
         endcase
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // Hold the response side off while words keep coming so the input backs up.
            if ((phase == 0 || phase == 3) && n == PHASE_ITEMS / 2) hold_request = 1'b1;
            drive_request(random_req());
         end
      end

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #40_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/tkst_pkg.sv
rtl/tkst_stream_if.sv
rtl/tkst_datapath.sv
rtl/tkst_ctrl.sv
rtl/top_k_score_table_unit.sv
bench/top_k_score_table_unit_test.sv
